>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsc_pkg
// Widths, word types and control structs shared by the step counter modules.
// ----------------------------------------------------------------------------
package mdsc_pkg;

    // Width of one signed axis sample.
    localparam int SAMPLE_BITS = 16;

    // Sum of three squares needs two more bits than one square.
    localparam int SUM_W  = 2 * SAMPLE_BITS + 2;
    // The root has half the bits of the radicand.
    localparam int ROOT_W = SUM_W / 2;
    // The partial remainder never exceeds twice the partial root.
    localparam int REM_W  = ROOT_W + 2;
    localparam int ITER_W = $clog2(ROOT_W);

    localparam int MAG_W   = 16;
    localparam int COUNT_W = 32;
    localparam int THR_W   = 16;

    localparam logic [MAG_W-1:0] MAG_MAX       = '1;
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(10);

    // Squaring runs three products plus a final step to drain the last one.
    localparam logic [1:0] SQ_LAST = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] axis_x;
        logic signed [SAMPLE_BITS-1:0] axis_y;
        logic signed [SAMPLE_BITS-1:0] axis_z;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] steps_total;
        logic               step_seen;
        logic [MAG_W-1:0]   magnitude;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic square;
        logic root_step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sq_last;
        logic root_last;
    } t_status;

endpackage

>>> rtl/mdsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsc_ctrl
// Sequencer for one sample: capture, square and sum, square root, commit.
// Also owns the valid flag of the output word register.
// ----------------------------------------------------------------------------
module mdsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mdsc_pkg::t_status i_status,
    output mdsc_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SQUARE = 2'd1;
    localparam logic [1:0] S_ROOT   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                if (i_status.sq_last) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, cleared when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // No word is taken while reset is held.
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/mdsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsc_datapath
// Shared squaring multiplier, digit-by-digit square root, threshold compare,
// saturating step counter and the output word register.
// ----------------------------------------------------------------------------
module mdsc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mdsc_pkg::THR_W-1:0]    i_cfg_data,
    input  mdsc_pkg::t_in_word            i_in_word,
    input  mdsc_pkg::t_cmd                i_cmd,
    output mdsc_pkg::t_status             o_status,
    output mdsc_pkg::t_out_word           o_out_word
);

    localparam int SB     = mdsc_pkg::SAMPLE_BITS;
    localparam int SUM_W  = mdsc_pkg::SUM_W;
    localparam int ROOT_W = mdsc_pkg::ROOT_W;
    localparam int REM_W  = mdsc_pkg::REM_W;
    localparam int ITER_W = mdsc_pkg::ITER_W;
    localparam int MAG_W  = mdsc_pkg::MAG_W;
    localparam int CNT_W  = mdsc_pkg::COUNT_W;
    localparam int THR_W  = mdsc_pkg::THR_W;
    localparam int EXT_W  = MAG_W + ROOT_W;

    // Sample and arithmetic registers.
    mdsc_pkg::t_in_word       r_sample;
    logic [1:0]               r_sel;
    logic [2*SB-1:0]          r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [ITER_W-1:0]        r_iter;

    // Architectural state.
    logic [THR_W-1:0]         r_threshold;
    logic [MAG_W-1:0]         r_prev_mag;
    logic [CNT_W-1:0]         r_count;
    mdsc_pkg::t_out_word      r_out_word;

    logic signed [SB-1:0]     sq_op;
    logic signed [2*SB-1:0]   sq_res;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         trial;
    logic                     trial_ok;
    logic [EXT_W-1:0]         root_ext;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W:0]           limit;
    logic                     step;
    logic [CNT_W-1:0]         n_count;

    // Squaring operand picked by the sequence counter.
    always_comb begin
        case (r_sel)
            2'd0:    sq_op = r_sample.axis_x;
            2'd1:    sq_op = r_sample.axis_y;
            default: sq_op = r_sample.axis_z;
        endcase
    end

    assign sq_res = sq_op * sq_op;

    // One root digit: bring down two radicand bits and try (root << 2) | 1.
    assign rem_sh   = {r_rem[REM_W-3:0], r_sum[SUM_W-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign trial_ok = (rem_sh >= trial);

    // Clamp the root to the magnitude width.
    assign root_ext = {{MAG_W{1'b0}}, r_root};
    assign mag      = (root_ext > EXT_W'(mdsc_pkg::MAG_MAX)) ? mdsc_pkg::MAG_MAX
                                                             : root_ext[MAG_W-1:0];

    // A step counts when the magnitude rises by more than the threshold.
    assign limit = {1'b0, r_prev_mag} + {1'b0, r_threshold};
    assign step  = ({1'b0, mag} > limit);

    always_comb begin
        n_count = r_count;
        if (step && (r_count != {CNT_W{1'b1}})) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= '0;
            r_iter <= '0;
        end else if (i_cmd.capture) begin
            r_sel  <= '0;
            r_iter <= '0;
        end else begin
            if (i_cmd.square) begin
                r_sel <= r_sel + 2'd1;
            end
            if (i_cmd.root_step) begin
                r_iter <= r_iter + ITER_W'(1);
            end
        end
    end

    // Sample capture, squaring pipeline and root iterations.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_in_word;
            r_sum    <= '0;
            r_rem    <= '0;
            r_root   <= '0;
        end else if (i_cmd.square) begin
            r_prod <= $unsigned(sq_res);
            if (r_sel != 2'd0) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end else if (i_cmd.root_step) begin
            r_sum <= {r_sum[SUM_W-3:0], 2'b00};
            if (trial_ok) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Threshold register and per-sample state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= mdsc_pkg::THRESHOLD_RST;
            r_prev_mag  <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_prev_mag <= mag;
                r_count    <= n_count;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_word.steps_total <= n_count;
            r_out_word.step_seen   <= step;
            r_out_word.magnitude   <= mag;
        end
    end

    assign o_status.sq_last   = (r_sel == mdsc_pkg::SQ_LAST);
    assign o_status.root_last = (r_iter == ITER_W'(ROOT_W - 1));
    assign o_out_word         = r_out_word;

endmodule

>>> rtl/magnitude_delta_step_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnitude_delta_step_counter
// Step counter on the rise of the three-axis vector magnitude between
// successive samples, with a programmable rise threshold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        sink       i_in_valid / o_in_ready    i_in_word  (t_in_word)
//  out       source     o_out_valid / i_out_ready  o_out_word (t_out_word)
//  cfg       sink       i_cfg_we, no wait          i_cfg_data (step threshold)
//
//  From acceptance to the next acceptance a word goes through a capture
//  step, the squaring on the shared multiplier, the one-digit-per-cycle
//  square root, and a commit step.
//  The result word sits in an output register, so a new word is accepted
//  while it waits; a commit stalls only if the previous result is still held.
//  Reset is synchronous and active low; the threshold returns to 10 and the
//  count and stored magnitude to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module magnitude_delta_step_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mdsc_pkg::THR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mdsc_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mdsc_pkg::t_out_word           o_out_word
);

    mdsc_pkg::t_cmd    cmd;
    mdsc_pkg::t_status status;

    mdsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mdsc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

    // No arithmetic runs while the block is ready for a new word.
    `ASSERT_IMPLIES(a_ready_quiet, i_clk, i_rst_n, o_in_ready, !(cmd.square || cmd.root_step || cmd.commit))

    // A commit never overwrites a result that has not been taken.
    `ASSERT_IMPLIES(a_commit_free, i_clk, i_rst_n, cmd.commit, !o_out_valid || i_out_ready)

    // A commit always presents a result in the next cycle.
    `ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, cmd.commit, o_out_valid)

    // An accepted word goes straight into the squaring phase.
    `ASSERT_NEXT(a_accept_squares, i_clk, i_rst_n, i_in_valid && o_in_ready, cmd.square)

endmodule
